[sv/rtdc_pkg.sv]
package rtdc_pkg;

    localparam int SENSOR_FULL_SCALE_DEFAULT = 1023;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_BRAKE_THRESHOLD      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PEDAL_MISMATCH_LIMIT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_START_HOLD_MS        = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BUZZER_HOLD_MS       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_FAULT_HOLD_MS        = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_REVERSE_DIRECTION    = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_BATTERY_READY_CODE   = 3'd6;

    // vehicle modes
    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_START  = 2'd1;
    localparam logic [1:0] MODE_BUZZER = 2'd2;
    localparam logic [1:0] MODE_DRIVE  = 2'd3;

    localparam logic [28:0] STATUS_ID     = 29'h186040F3;
    localparam int          TORQUE_LIMIT  = 32767;
    localparam int          PEDAL_SCALE_NUM = 50;
    localparam int          PEDAL_SCALE_DEN = 33;

    typedef struct packed {
        logic [9:0]  brake_threshold;
        logic [10:0] pedal_mismatch_limit;
        logic [15:0] start_hold_ms;
        logic [15:0] buzzer_hold_ms;
        logic [15:0] fault_hold_ms;
        logic        reverse_direction;
        logic [7:0]  battery_ready_code;
    } cfg_t;

    typedef struct packed {
        logic [31:0] now_ms;
        logic [9:0]  brake_level;
        logic        start_pressed;
        logic [9:0]  pedal_low_raw;
        logic [9:0]  pedal_high_raw;
        logic        status_frame_valid;
        logic [28:0] status_frame_id;
        logic [7:0]  status_frame_byte;
    } sample_t;

    typedef struct packed {
        logic [1:0]         vehicle_state;
        logic               brake_lamp;
        logic               buzzer_on;
        logic               drive_lamp;
        logic               torque_valid;
        logic signed [15:0] torque_command;
        logic               fault_active;
        logic               fault_report;
        logic [10:0]        pedal_low_scaled;
        logic [10:0]        pedal_difference;
        logic               battery_ready;
    } result_t;

endpackage

[sv/vehicle_ready_to_drive_controller_unit.sv]
// Ready-to-drive controller: takes one control-loop sample per beat and returns one result
// beat for it. A sample accepted at one clock edge sits in the input register, is evaluated
// and moved into the result register once that one is empty or draining, and is offered as
// a result beat from then on; with no stall on either side a new sample is taken at every
// edge. While a result beat waits on out_stall the input register still takes one more
// sample, and the input stalls only once both registers are full.
// Brake plus start button held for start_hold_ms (with battery ready) sounds the buzzer;
// after buzzer_hold_ms the block enters drive and commands torque from the high pedal
// sensor. A pedal disagreement lasting fault_hold_ms sends zero torque and drops to idle.
// Configuration registers may be written only while no sample is in flight.
module vehicle_ready_to_drive_controller_unit #(
    parameter int SENSOR_FULL_SCALE = rtdc_pkg::SENSOR_FULL_SCALE_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              cfg_we,
    input  logic [rtdc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [rtdc_pkg::CFG_DATA_W-1:0]   cfg_wdata,

    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [31:0]                       now_ms,
    input  logic [9:0]                        brake_level,
    input  logic                              start_pressed,
    input  logic [9:0]                        pedal_low_raw,
    input  logic [9:0]                        pedal_high_raw,
    input  logic                              status_frame_valid,
    input  logic [28:0]                       status_frame_id,
    input  logic [7:0]                        status_frame_byte,

    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [1:0]                        vehicle_state,
    output logic                              brake_lamp,
    output logic                              buzzer_on,
    output logic                              drive_lamp,
    output logic                              torque_valid,
    output logic signed [15:0]                torque_command,
    output logic                              fault_active,
    output logic                              fault_report,
    output logic [10:0]                       pedal_low_scaled,
    output logic [10:0]                       pedal_difference,
    output logic                              battery_ready
);
    import rtdc_pkg::*;

    cfg_t    cfg;
    sample_t sample_reg;
    logic    sample_valid_reg;
    result_t result;
    result_t result_reg;
    logic    result_valid_reg;
    logic    advance;
    logic    in_take;

    // input register moves into the result register when that one is empty or draining
    assign advance  = sample_valid_reg && (!result_valid_reg || !out_stall);
    assign in_stall = sample_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    rtdc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    rtdc_step #(
        .SENSOR_FULL_SCALE (SENSOR_FULL_SCALE)
    ) u_step (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .sample (sample_reg),
        .cfg    (cfg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_valid_reg <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                sample_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                sample_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            sample_reg.now_ms             <= now_ms;
            sample_reg.brake_level        <= brake_level;
            sample_reg.start_pressed      <= start_pressed;
            sample_reg.pedal_low_raw      <= pedal_low_raw;
            sample_reg.pedal_high_raw     <= pedal_high_raw;
            sample_reg.status_frame_valid <= status_frame_valid;
            sample_reg.status_frame_id    <= status_frame_id;
            sample_reg.status_frame_byte  <= status_frame_byte;
        end
        if (advance)
        begin
            result_reg <= result;
        end
    end

    assign out_valid        = result_valid_reg;
    assign vehicle_state    = result_reg.vehicle_state;
    assign brake_lamp       = result_reg.brake_lamp;
    assign buzzer_on        = result_reg.buzzer_on;
    assign drive_lamp       = result_reg.drive_lamp;
    assign torque_valid     = result_reg.torque_valid;
    assign torque_command   = result_reg.torque_command;
    assign fault_active     = result_reg.fault_active;
    assign fault_report     = result_reg.fault_report;
    assign pedal_low_scaled = result_reg.pedal_low_scaled;
    assign pedal_difference = result_reg.pedal_difference;
    assign battery_ready    = result_reg.battery_ready;

endmodule

[sv/rtdc_cfg.sv]
module rtdc_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [rtdc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [rtdc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output rtdc_pkg::cfg_t                    cfg
);
    import rtdc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_BRAKE_THRESHOLD:      cfg_next.brake_threshold      = cfg_wdata[9:0];
                REG_PEDAL_MISMATCH_LIMIT: cfg_next.pedal_mismatch_limit = cfg_wdata[10:0];
                REG_START_HOLD_MS:        cfg_next.start_hold_ms        = cfg_wdata[15:0];
                REG_BUZZER_HOLD_MS:       cfg_next.buzzer_hold_ms       = cfg_wdata[15:0];
                REG_FAULT_HOLD_MS:        cfg_next.fault_hold_ms        = cfg_wdata[15:0];
                REG_REVERSE_DIRECTION:    cfg_next.reverse_direction    = cfg_wdata[0];
                REG_BATTERY_READY_CODE:   cfg_next.battery_ready_code   = cfg_wdata[7:0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.brake_threshold      <= 10'd102;
            cfg_reg.pedal_mismatch_limit <= 11'd102;
            cfg_reg.start_hold_ms        <= 16'd2000;
            cfg_reg.buzzer_hold_ms       <= 16'd2000;
            cfg_reg.fault_hold_ms        <= 16'd100;
            cfg_reg.reverse_direction    <= 1'b0;
            cfg_reg.battery_ready_code   <= 8'd80;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[sv/rtdc_step.sv]
module rtdc_step #(
    parameter int SENSOR_FULL_SCALE = rtdc_pkg::SENSOR_FULL_SCALE_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  rtdc_pkg::sample_t   sample,
    input  rtdc_pkg::cfg_t      cfg,
    output rtdc_pkg::result_t   result
);
    import rtdc_pkg::*;

    // reciprocal scaling, exact for numerators below 2^16 (pedal) and 2^25 (torque)
    localparam int LOW_SHIFT = 16 + $clog2(PEDAL_SCALE_DEN);
    localparam longint unsigned LOW_FACTOR = PEDAL_SCALE_NUM
        * (((64'd1 << LOW_SHIFT) + PEDAL_SCALE_DEN - 1) / PEDAL_SCALE_DEN);
    localparam int MAG_SHIFT = 25 + $clog2(SENSOR_FULL_SCALE);
    localparam longint unsigned MAG_FACTOR = TORQUE_LIMIT
        * (((64'd1 << MAG_SHIFT) + SENSOR_FULL_SCALE - 1) / SENSOR_FULL_SCALE);

    logic [1:0]  mode_reg;
    logic [1:0]  mode_next;
    logic [31:0] entry_stamp_reg;
    logic [31:0] entry_stamp_next;
    logic [31:0] fault_stamp_reg;
    logic [31:0] fault_stamp_next;
    logic        fault_pending_reg;
    logic        fault_pending_next;
    logic        battery_ok_reg;
    logic        battery_ok_next;

    logic        brake_on;
    logic [31:0] entry_elapsed;
    logic [47:0] low_product;
    logic [10:0] scaled;
    logic [10:0] diff;
    logic [63:0] high_product;
    logic [24:0] mag_full;
    logic [15:0] mag;

    assign brake_on      = sample.brake_level > cfg.brake_threshold;
    assign entry_elapsed = sample.now_ms - entry_stamp_reg;

    // 50/33 scaling, at most 1550
    assign low_product = 48'(sample.pedal_low_raw) * 48'(LOW_FACTOR);
    assign scaled      = 11'(low_product >> LOW_SHIFT);
    assign diff        = (scaled >= 11'(sample.pedal_high_raw))
                       ? scaled - 11'(sample.pedal_high_raw)
                       : 11'(sample.pedal_high_raw) - scaled;

    assign high_product = 64'(sample.pedal_high_raw) * 64'(MAG_FACTOR);
    assign mag_full     = 25'(high_product >> MAG_SHIFT);
    assign mag          = (mag_full > 25'(TORQUE_LIMIT)) ? 16'(TORQUE_LIMIT) : mag_full[15:0];

    always_comb
    begin
        logic [31:0] fault_elapsed;

        mode_next          = mode_reg;
        entry_stamp_next   = entry_stamp_reg;
        fault_stamp_next   = fault_stamp_reg;
        fault_pending_next = fault_pending_reg;
        battery_ok_next    = battery_ok_reg;
        fault_elapsed      = '0;
        result             = '0;

        if (sample.status_frame_valid && sample.status_frame_id == STATUS_ID)
        begin
            battery_ok_next = (sample.status_frame_byte == cfg.battery_ready_code);
        end

        case (mode_reg)
            MODE_IDLE:
            begin
                if (sample.start_pressed && brake_on)
                begin
                    mode_next        = MODE_START;
                    entry_stamp_next = sample.now_ms;
                end
            end
            MODE_START:
            begin
                if (!brake_on || !sample.start_pressed)
                begin
                    mode_next        = MODE_IDLE;
                    entry_stamp_next = sample.now_ms;
                end
                else if (entry_elapsed >= 32'(cfg.start_hold_ms) && battery_ok_next)
                begin
                    mode_next        = MODE_BUZZER;
                    entry_stamp_next = sample.now_ms;
                end
            end
            MODE_BUZZER:
            begin
                if (entry_elapsed >= 32'(cfg.buzzer_hold_ms))
                begin
                    mode_next        = MODE_DRIVE;
                    entry_stamp_next = sample.now_ms;
                end
            end
            MODE_DRIVE:
            begin
                result.pedal_low_scaled = scaled;
                result.pedal_difference = diff;
                if (diff > cfg.pedal_mismatch_limit)
                begin
                    if (!fault_pending_reg)
                    begin
                        fault_pending_next  = 1'b1;
                        fault_stamp_next    = sample.now_ms;
                        result.fault_report = 1'b1;
                    end
                    fault_elapsed = sample.now_ms - fault_stamp_next;
                    if (fault_elapsed >= 32'(cfg.fault_hold_ms))
                    begin
                        result.torque_valid = 1'b1;
                        mode_next           = MODE_IDLE;
                        entry_stamp_next    = sample.now_ms;
                        fault_pending_next  = 1'b0;
                    end
                end
                else
                begin
                    fault_pending_next    = 1'b0;
                    result.torque_valid   = 1'b1;
                    result.torque_command = cfg.reverse_direction ? -$signed(mag)
                                                                  : $signed(mag);
                end
            end
            default:
            begin
                mode_next = MODE_IDLE;
            end
        endcase

        result.vehicle_state = mode_next;
        result.brake_lamp    = brake_on;
        result.buzzer_on     = (mode_next == MODE_BUZZER);
        result.drive_lamp    = (mode_next == MODE_DRIVE);
        result.fault_active  = fault_pending_next;
        result.battery_ready = battery_ok_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= MODE_IDLE;
            entry_stamp_reg   <= '0;
            fault_stamp_reg   <= '0;
            fault_pending_reg <= 1'b0;
            battery_ok_reg    <= 1'b0;
        end
        else if (fire)
        begin
            mode_reg          <= mode_next;
            entry_stamp_reg   <= entry_stamp_next;
            fault_stamp_reg   <= fault_stamp_next;
            fault_pending_reg <= fault_pending_next;
            battery_ok_reg    <= battery_ok_next;
        end
    end

endmodule

[sv/rtdc_checker.sv]
module rtdc_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [1:0]         vehicle_state,
    input  logic               buzzer_on,
    input  logic               drive_lamp,
    input  logic               torque_valid,
    input  logic signed [15:0] torque_command,
    input  logic               fault_report
);
    import rtdc_pkg::*;

    // a stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(torque_command)
                                   && $stable(vehicle_state))
        else $error("stalled result beat changed");

    // no torque command means a zero command word
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !torque_valid |-> torque_command == 16'sd0)
        else $error("torque word set without torque valid");

    // a fault report comes only from drive: the result stays in drive or drops to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fault_report |-> vehicle_state == MODE_DRIVE
                                      || vehicle_state == MODE_IDLE)
        else $error("fault report outside drive");

    // buzzer phase sends no torque and lamps follow the state
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && buzzer_on |-> vehicle_state == MODE_BUZZER && !torque_valid
                                   && !drive_lamp)
        else $error("buzzer beat inconsistent");

endmodule

bind vehicle_ready_to_drive_controller_unit rtdc_checker u_rtdc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .vehicle_state  (vehicle_state),
    .buzzer_on      (buzzer_on),
    .drive_lamp     (drive_lamp),
    .torque_valid   (torque_valid),
    .torque_command (torque_command),
    .fault_report   (fault_report)
);

[tb/sv/vehicle_ready_to_drive_controller_unit_tb.sv]
module vehicle_ready_to_drive_controller_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import rtdc_pkg::*;

    localparam int CLK_PERIOD = 10;
    localparam int STALL_LIMIT = 2000;
    localparam int REPORT_LINES = 60;
    localparam int MAX_WAIT = 17;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    logic in_valid = 1'b0;
    logic in_stall;
    sample_t tx_beat = '0;

    logic out_valid;
    logic out_stall = 1'b0;
    logic [1:0] vehicle_state;
    logic brake_lamp;
    logic buzzer_on;
    logic drive_lamp;
    logic torque_valid;
    logic signed [15:0] torque_command;
    logic fault_active;
    logic fault_report;
    logic [10:0] pedal_low_scaled;
    logic [10:0] pedal_difference;
    logic battery_ready;

    // controller shadow state and register copy
    logic [1:0] ctl_mode;
    logic [31:0] ctl_entry_stamp;
    logic [31:0] ctl_fault_stamp;
    logic ctl_fault_pending;
    logic ctl_battery_ok;
    cfg_t ctl_cfg;

    result_t vehicle_results_due[$];
    logic [31:0] t_ms;
    int samples_sent = 0;
    int results_seen = 0;
    int mismatches = 0;
    int idle_cycles = 0;
    int rx_hold_req = 0;
    bit tx_eager = 1'b0;
    bit rx_eager = 1'b0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    vehicle_ready_to_drive_controller_unit dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .now_ms             (tx_beat.now_ms),
        .brake_level        (tx_beat.brake_level),
        .start_pressed      (tx_beat.start_pressed),
        .pedal_low_raw      (tx_beat.pedal_low_raw),
        .pedal_high_raw     (tx_beat.pedal_high_raw),
        .status_frame_valid (tx_beat.status_frame_valid),
        .status_frame_id    (tx_beat.status_frame_id),
        .status_frame_byte  (tx_beat.status_frame_byte),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .vehicle_state      (vehicle_state),
        .brake_lamp         (brake_lamp),
        .buzzer_on          (buzzer_on),
        .drive_lamp         (drive_lamp),
        .torque_valid       (torque_valid),
        .torque_command     (torque_command),
        .fault_active       (fault_active),
        .fault_report       (fault_report),
        .pedal_low_scaled   (pedal_low_scaled),
        .pedal_difference   (pedal_difference),
        .battery_ready      (battery_ready)
    );

    function automatic result_t step_controller(sample_t s);
        result_t r;
        logic brake_on;
        logic [31:0] since_entry;
        logic [31:0] since_fault;
        int unsigned lo;
        int unsigned hi;
        int unsigned scaled;
        int unsigned diff;
        int unsigned mag;
        r = '0;
        brake_on = s.brake_level > ctl_cfg.brake_threshold;
        // battery flag updates ahead of the mode logic
        if (s.status_frame_valid && s.status_frame_id == STATUS_ID)
            ctl_battery_ok = (s.status_frame_byte == ctl_cfg.battery_ready_code);
        since_entry = s.now_ms - ctl_entry_stamp;
        case (ctl_mode)
            MODE_IDLE:
            begin
                if (s.start_pressed && brake_on)
                begin
                    ctl_mode = MODE_START;
                    ctl_entry_stamp = s.now_ms;
                end
            end
            MODE_START:
            begin
                if (!brake_on || !s.start_pressed)
                begin
                    ctl_mode = MODE_IDLE;
                    ctl_entry_stamp = s.now_ms;
                end
                else if (since_entry >= ctl_cfg.start_hold_ms && ctl_battery_ok)
                begin
                    ctl_mode = MODE_BUZZER;
                    ctl_entry_stamp = s.now_ms;
                end
            end
            MODE_BUZZER:
            begin
                if (since_entry >= ctl_cfg.buzzer_hold_ms)
                begin
                    ctl_mode = MODE_DRIVE;
                    ctl_entry_stamp = s.now_ms;
                end
            end
            default:
            begin
                lo = s.pedal_low_raw;
                hi = s.pedal_high_raw;
                scaled = lo * PEDAL_SCALE_NUM / PEDAL_SCALE_DEN;
                diff = (scaled >= hi) ? scaled - hi : hi - scaled;
                r.pedal_low_scaled = scaled[10:0];
                r.pedal_difference = diff[10:0];
                if (diff > ctl_cfg.pedal_mismatch_limit)
                begin
                    if (!ctl_fault_pending)
                    begin
                        ctl_fault_pending = 1'b1;
                        ctl_fault_stamp = s.now_ms;
                        r.fault_report = 1'b1;
                    end
                    since_fault = s.now_ms - ctl_fault_stamp;
                    // a persistent fault cuts torque and drops out of drive
                    if (since_fault >= ctl_cfg.fault_hold_ms)
                    begin
                        r.torque_valid = 1'b1;
                        r.torque_command = '0;
                        ctl_mode = MODE_IDLE;
                        ctl_entry_stamp = s.now_ms;
                        ctl_fault_pending = 1'b0;
                    end
                end
                else
                begin
                    mag = hi * TORQUE_LIMIT / SENSOR_FULL_SCALE_DEFAULT;
                    if (mag > TORQUE_LIMIT)
                        mag = TORQUE_LIMIT;
                    ctl_fault_pending = 1'b0;
                    r.torque_valid = 1'b1;
                    r.torque_command = ctl_cfg.reverse_direction ? 16'(0 - mag) : 16'(mag);
                end
            end
        endcase
        r.vehicle_state = ctl_mode;
        r.brake_lamp = brake_on;
        r.buzzer_on = (ctl_mode == MODE_BUZZER);
        r.drive_lamp = (ctl_mode == MODE_DRIVE);
        r.fault_active = ctl_fault_pending;
        r.battery_ready = ctl_battery_ok;
        return r;
    endfunction

    task automatic log_mismatch(input string msg);
        if (mismatches < REPORT_LINES)
            $display("ERROR @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            log_mismatch($sformatf("result %0d %s: got %0h, want %0h",
                                   results_seen, name, got, want));
    endtask

    // acceptance on both sides, prediction and comparison
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                vehicle_results_due.push_back(step_controller(tx_beat));
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (vehicle_results_due.size() == 0)
                begin
                    log_mismatch($sformatf("result %0d with no sample outstanding",
                                           results_seen));
                end
                else
                begin
                    want = vehicle_results_due.pop_front();
                    check_field("vehicle_state", vehicle_state, want.vehicle_state);
                    check_field("brake_lamp", brake_lamp, want.brake_lamp);
                    check_field("buzzer_on", buzzer_on, want.buzzer_on);
                    check_field("drive_lamp", drive_lamp, want.drive_lamp);
                    check_field("torque_valid", torque_valid, want.torque_valid);
                    check_field("torque_command", torque_command, want.torque_command);
                    check_field("fault_active", fault_active, want.fault_active);
                    check_field("fault_report", fault_report, want.fault_report);
                    check_field("pedal_low_scaled", pedal_low_scaled,
                                want.pedal_low_scaled);
                    check_field("pedal_difference", pedal_difference,
                                want.pedal_difference);
                    check_field("battery_ready", battery_ready, want.battery_ready);
                end
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    // result side: random stall before each beat (none when eager), or a requested long hold-off
    initial
    begin : receiver
        int n;
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            if (rx_hold_req > 0)
            begin
                n = rx_hold_req;
                rx_hold_req = 0;
            end
            else if (rx_eager)
                n = 0;
            else
                n = $urandom_range(0, MAX_WAIT);
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!(out_valid && !out_stall));
            @(negedge clk);
        end
    end

    initial
    begin : watchdog
        wait (rst_n);
        while (idle_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("ERROR: no beat moved for %0d cycles", STALL_LIMIT);
        $display("vehicle_ready_to_drive_controller_unit: mismatch");
        $finish;
    end

    // called and returns at a falling edge
    task automatic send_sample(input sample_t s);
        int gap;
        gap = tx_eager ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        tx_beat <= s;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        samples_sent++;
    endtask

    task automatic quiesce();
        in_valid <= 1'b0;
        while (vehicle_results_due.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    function automatic cfg_t make_settings(logic [9:0] brake_thr, logic [10:0] mismatch,
                                           logic [15:0] start_hold, logic [15:0] buzz_hold,
                                           logic [15:0] fault_hold, logic reverse,
                                           logic [7:0] ready_code);
        cfg_t c;
        c.brake_threshold = brake_thr;
        c.pedal_mismatch_limit = mismatch;
        c.start_hold_ms = start_hold;
        c.buzzer_hold_ms = buzz_hold;
        c.fault_hold_ms = fault_hold;
        c.reverse_direction = reverse;
        c.battery_ready_code = ready_code;
        return c;
    endfunction

    // writes every register, with junk above the narrower fields, plus the unused index
    task automatic apply_settings(input cfg_t c);
        int i;
        logic [CFG_INDEX_W-1:0] idx;
        logic [CFG_DATA_W-1:0] wd;
        quiesce();
        for (i = 0; i <= int'(REG_UNUSED); i++)
        begin
            idx = 3'(i);
            wd = 16'($urandom);
            case (idx)
                REG_BRAKE_THRESHOLD:      wd[9:0] = c.brake_threshold;
                REG_PEDAL_MISMATCH_LIMIT: wd[10:0] = c.pedal_mismatch_limit;
                REG_START_HOLD_MS:        wd = c.start_hold_ms;
                REG_BUZZER_HOLD_MS:       wd = c.buzzer_hold_ms;
                REG_FAULT_HOLD_MS:        wd = c.fault_hold_ms;
                REG_REVERSE_DIRECTION:    wd[0] = c.reverse_direction;
                REG_BATTERY_READY_CODE:   wd[7:0] = c.battery_ready_code;
                default:                  ;
            endcase
            cfg_we <= 1'b1;
            cfg_index <= idx;
            cfg_wdata <= wd;
            @(negedge clk);
        end
        cfg_we <= 1'b0;
        ctl_cfg = c;
    endtask

    function automatic sample_t quiet_sample(logic [31:0] now, logic [9:0] brake,
                                             logic start, logic [9:0] low, logic [9:0] high);
        sample_t s;
        s = '0;
        s.now_ms = now;
        s.brake_level = brake;
        s.start_pressed = start;
        s.pedal_low_raw = low;
        s.pedal_high_raw = high;
        return s;
    endfunction

    function automatic logic [31:0] advance_ms();
        int unsigned longest;
        longest = ctl_cfg.start_hold_ms;
        if (ctl_cfg.buzzer_hold_ms > longest)
            longest = ctl_cfg.buzzer_hold_ms;
        if (ctl_cfg.fault_hold_ms > longest)
            longest = ctl_cfg.fault_hold_ms;
        t_ms += $urandom_range(0, longest / 3 + 4);
        return t_ms;
    endfunction

    function automatic logic [9:0] pressed_brake();
        if (ctl_cfg.brake_threshold == 10'h3FF)
            return 10'h3FF;
        return 10'($urandom_range(int'(ctl_cfg.brake_threshold) + 1, 1023));
    endfunction

    // low sensor reading whose 50/33 scaling lands within three counts of high
    function automatic logic [9:0] matching_low(logic [9:0] high);
        int l;
        l = (int'(high) * 33 + 25) / 50 + $urandom_range(0, 2) - 1;
        if (l < 0)
            l = 0;
        return 10'(l);
    endfunction

    function automatic sample_t random_sample();
        sample_t s;
        if ($urandom_range(0, 9) == 0)
            t_ms = $urandom;
        s.now_ms = ($urandom_range(0, 4) == 0) ? 32'($urandom) : advance_ms();
        s.brake_level = 10'($urandom);
        s.start_pressed = 1'($urandom);
        s.pedal_low_raw = 10'($urandom);
        s.pedal_high_raw = 10'($urandom);
        s.status_frame_valid = 1'($urandom);
        s.status_frame_id = ($urandom_range(0, 3) == 0) ? STATUS_ID : 29'($urandom);
        s.status_frame_byte = ($urandom_range(0, 2) == 0) ? ctl_cfg.battery_ready_code
                                                          : 8'($urandom);
        return s;
    endfunction

    function automatic logic [15:0] pick_hold();
        return ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 500));
    endfunction

    // battery mostly ready, button and brake mostly held through start hold and buzzer, then pedal work
    task automatic drive_session();
        sample_t s;
        int guard;
        int steps;
        s = random_sample();
        s.now_ms = advance_ms();
        s.start_pressed = 1'b1;
        s.brake_level = pressed_brake();
        s.status_frame_valid = 1'b1;
        s.status_frame_id = STATUS_ID;
        s.status_frame_byte = ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                          : ctl_cfg.battery_ready_code;
        send_sample(s);
        guard = 0;
        while (ctl_mode != MODE_DRIVE && guard < 30)
        begin
            s = random_sample();
            s.now_ms = advance_ms();
            s.start_pressed = ($urandom_range(0, 19) != 0);
            if ($urandom_range(0, 19) != 0)
                s.brake_level = pressed_brake();
            if ($urandom_range(0, 4) != 0)
                s.status_frame_valid = 1'b0;
            send_sample(s);
            guard++;
        end
        steps = $urandom_range(2, 25);
        while (ctl_mode == MODE_DRIVE && steps > 0)
        begin
            s = random_sample();
            s.now_ms = advance_ms();
            if ($urandom_range(0, 6) != 0)
                s.pedal_low_raw = matching_low(s.pedal_high_raw);
            send_sample(s);
            steps--;
        end
    endtask

    task automatic run_traffic(input int n);
        int goal;
        goal = samples_sent + n;
        while (samples_sent < goal)
        begin
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 6)) send_sample(random_sample());
            else
                drive_session();
        end
    endtask

    // reset settings: walk every mode, boundaries, wrap of the millisecond counter
    task automatic test_directed_walkthrough();
        sample_t s;
        logic [31:0] t0;
        logic [31:0] tf;
        t0 = 32'hFFFF_F000;
        s = quiet_sample(32'd0, 10'd0, 1'b0, 10'd0, 10'd0);
        s.status_frame_valid = 1'b1;
        s.status_frame_id = STATUS_ID;
        s.status_frame_byte = 8'hFF;
        send_sample(s);
        // foreign frame id carrying the ready code is ignored
        s = quiet_sample(32'hFFFF_FFFF, 10'h3FF, 1'b0, 10'h3FF, 10'h3FF);
        s.status_frame_valid = 1'b1;
        s.status_frame_id = 29'h1FFF_FFFF;
        s.status_frame_byte = 8'd80;
        send_sample(s);
        // status id without the valid flag; brake exactly at threshold is not pressed
        s = quiet_sample(t0, 10'd102, 1'b1, 10'd0, 10'd0);
        s.status_frame_id = STATUS_ID;
        s.status_frame_byte = 8'd80;
        send_sample(s);
        s = quiet_sample(t0, 10'd103, 1'b1, 10'd0, 10'd0);
        s.status_frame_valid = 1'b1;
        s.status_frame_id = STATUS_ID;
        s.status_frame_byte = 8'd80;
        send_sample(s);
        send_sample(quiet_sample(t0 + 1999, 10'h3FF, 1'b1, 10'd0, 10'd0));
        send_sample(quiet_sample(t0 + 1999, 10'h3FF, 1'b0, 10'd0, 10'd0));
        send_sample(quiet_sample(t0 + 2500, 10'h3FF, 1'b1, 10'd0, 10'd0));
        // hold time met across the wrap, but battery just went not-ready
        s = quiet_sample(t0 + 4500, 10'h3FF, 1'b1, 10'd0, 10'd0);
        s.status_frame_valid = 1'b1;
        s.status_frame_id = STATUS_ID;
        s.status_frame_byte = 8'd81;
        send_sample(s);
        s.now_ms = t0 + 4501;
        s.status_frame_byte = 8'd80;
        send_sample(s);
        send_sample(quiet_sample(t0 + 6500, 10'd0, 1'b0, 10'd0, 10'd0));
        send_sample(quiet_sample(t0 + 6501, 10'd0, 1'b0, 10'd0, 10'd0));
        tf = t0 + 7000;
        send_sample(quiet_sample(tf, 10'd0, 1'b0, 10'd0, 10'd0));
        send_sample(quiet_sample(tf + 1, 10'd0, 1'b0, 10'd675, 10'h3FF));
        send_sample(quiet_sample(tf + 2, 10'd0, 1'b0, 10'h3FF, 10'h3FF));
        send_sample(quiet_sample(tf + 101, 10'd0, 1'b0, 10'h3FF, 10'h3FF));
        // difference equal to the limit is still plausible
        send_sample(quiet_sample(tf + 150, 10'd0, 1'b0, 10'd0, 10'd102));
        send_sample(quiet_sample(tf + 200, 10'd0, 1'b0, 10'd0, 10'd103));
        send_sample(quiet_sample(tf + 300, 10'h3FF, 1'b1, 10'd0, 10'h3FF));
        send_sample(quiet_sample(tf + 301, 10'h3FF, 1'b0, 10'h3FF, 10'd0));
    endtask

    task automatic test_register_settings();
        cfg_t c[5];
        int i;
        c[0] = make_settings(10'd0, 11'd0, 16'd0, 16'd0, 16'd0, 1'b0, 8'd0);
        c[1] = make_settings(10'h3FF, 11'h7FF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 8'hFF);
        c[2] = make_settings(10'd300, 11'd150, 16'd50, 16'd30, 16'd20, 1'b1, 8'($urandom));
        c[3] = make_settings(10'h3FE, 11'h7FF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 8'hFF);
        c[4] = make_settings(10'd102, 11'd102, 16'd2000, 16'd2000, 16'd100, 1'b0, 8'd80);
        for (i = 0; i < 5; i++)
        begin
            apply_settings(c[i]);
            tx_eager = ($urandom_range(0, 3) == 0);
            rx_eager = ($urandom_range(0, 3) == 0);
            run_traffic(110);
        end
    endtask

    // long hold-off on the result side while samples keep coming
    task automatic test_output_backpressure();
        quiesce();
        tx_eager = 1'b1;
        rx_eager = 1'b0;
        rx_hold_req = 240;
        run_traffic(40);
        tx_eager = 1'b0;
        quiesce();
    endtask

    task automatic test_random_traffic();
        repeat (7)
        begin
            apply_settings(make_settings(
                ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(0, 600)),
                ($urandom_range(0, 1) == 0) ? 11'($urandom_range(0, 150)) : 11'($urandom),
                pick_hold(), pick_hold(), pick_hold(), 1'($urandom), 8'($urandom)));
            tx_eager = ($urandom_range(0, 3) == 0);
            rx_eager = ($urandom_range(0, 3) == 0);
            run_traffic(110);
        end
    endtask

    initial
    begin
        ctl_mode = MODE_IDLE;
        ctl_entry_stamp = '0;
        ctl_fault_stamp = '0;
        ctl_fault_pending = 1'b0;
        ctl_battery_ok = 1'b0;
        ctl_cfg = make_settings(10'd102, 11'd102, 16'd2000, 16'd2000, 16'd100, 1'b0, 8'd80);
        t_ms = $urandom;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed_walkthrough();
        test_register_settings();
        test_output_backpressure();
        test_random_traffic();
        quiesce();
        if (mismatches == 0)
            $display("vehicle_ready_to_drive_controller_unit: match");
        else
            $display("vehicle_ready_to_drive_controller_unit: mismatch");
        $finish;
    end

endmodule

[filelist.f]
sv/rtdc_pkg.sv
sv/rtdc_cfg.sv
sv/rtdc_step.sv
sv/vehicle_ready_to_drive_controller_unit.sv
sv/rtdc_checker.sv
tb/sv/vehicle_ready_to_drive_controller_unit_tb.sv
